/* sv/rational_arithmetic_unit_assert.svh */
// Assertion macros used by the checker of the rational arithmetic unit.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define RAU_ASSERT_NOW(lbl, trig, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error("rational arithmetic unit check failed");

// The consequent must hold in the cycle after the trigger.
`define RAU_ASSERT_NEXT(lbl, trig, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error("rational arithmetic unit check failed");

`endif

/* sv/rau_pkg.sv */
// Package of the rational arithmetic unit: operation codes, status codes and
// sequencer types. No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_NE  = 3'd5
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DIV0 = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DEN0 = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GCD_INIT,
		ST_GCD,
		ST_DIV,
		ST_RED_DONE,
		ST_OP,
		ST_MUL_INIT,
		ST_MUL,
		ST_COMBINE,
		ST_NEG,
		ST_DONE
	} state_t;

	// Which fraction the reduction sequence is working on.
	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_R
	} phase_t;

endpackage

/* sv/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: a sequencer around one shared
// adder that runs binary GCD, restoring division and shift-add multiplication.
// Depends on rau_pkg.
`timescale 1ns / 1ps

// Rational arithmetic unit. Takes two signed fractions and an operation (add,
// subtract, multiply, divide, equal, not equal) and returns the reduced result
// with a status. One word is worked on at a time; s_tready is high only while
// the unit is idle. Each of the three reductions (operand a, operand b, result)
// runs a binary GCD of its two values and, unless the GCD is one, two restoring
// divisions by it; every product is a shift-add multiplication. All of these go
// through the one shared adder, the divisions and products one bit per cycle,
// so the time a word takes depends on the values. A finished result sits in the
// output register until taken.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16,
	localparam int IN_TDW  = ((4 * OPERAND_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_TDW-1:0]  s_tdata,  // a_num, a_den, b_num, b_den
	input  logic [OP_W-1:0]    s_tuser,  // op
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_TDW-1:0] m_tdata,  // res_num, res_den
	output logic [2:0]         m_tuser   // cmp_true, status
);

	localparam int W  = OPERAND_WIDTH;
	localparam int M  = 2 * W;
	localparam int AW = M + 2;
	localparam int CW = $clog2(M);

	function automatic logic [W-1:0] mag_f(input logic [W-1:0] x);
		mag_f = x[W-1] ? (~x + W'(1)) : x;
	endfunction

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	op_t    op_q, op_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d, mp_q, mp_d;
	logic sa_q, sa_d, sb_q, sb_d, sr_q, sr_d, cmp_q, cmp_d, dsel_q, dsel_d;
	logic [M-1:0] rx_q, rx_d, ry_q, ry_d, gu_q, gu_d, gv_q, gv_d, g_q, g_d;
	logic [M-1:0] dq_q, dq_d, dr_q, dr_d, mc_q, mc_d, acc_q, acc_d;
	logic [M-1:0] p1_q, p1_d, p2_q, p2_d;
	logic [CW-1:0] gk_q, gk_d, cnt_q, cnt_d;
	logic [1:0] mstep_q, mstep_d;
	logic m_tvalid_q, m_tvalid_d;
	logic [M:0] onum_q, onum_d;
	logic [M-2:0] oden_q, oden_d;
	logic ocmp_q, ocmp_d;
	logic [STAT_W-1:0] ostat_q, ostat_d;

	// Shared adder.
	logic [AW-1:0] alu_a, alu_b, alu_res;
	logic alu_sub;
	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

	logic [W-1:0] an_in, ad_in, bn_in, bd_in, an_mag, ad_mag, bn_mag, bd_mag;
	logic [M-1:0] gshift, mc_sel, q_n, rem_n, acc_n;
	logic [W-1:0] mp_sel;
	logic nb, s2, addsub;

	assign an_in  = s_tdata[W-1:0];
	assign ad_in  = s_tdata[2*W-1:W];
	assign bn_in  = s_tdata[3*W-1:2*W];
	assign bd_in  = s_tdata[4*W-1:3*W];
	assign an_mag = mag_f(an_in);
	assign ad_mag = (ad_in == '0) ? W'(1) : mag_f(ad_in);
	assign bn_mag = mag_f(bn_in);
	assign bd_mag = (bd_in == '0) ? W'(1) : mag_f(bd_in);
	assign gshift = gv_q << gk_q;
	assign addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
	assign s2     = sb_q ^ (op_q == OP_SUB);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDW'({oden_q, onum_q});
	assign m_tuser  = {ostat_q, ocmp_q};

	// Operand pair for each product of an operation.
	always_comb begin
		mc_sel = {{W{1'b0}}, ad_q};
		mp_sel = bd_q;
		case (mstep_q)
			2'd0: begin
				mc_sel = {{W{1'b0}}, an_q};
				mp_sel = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				if (addsub) begin
					mc_sel = {{W{1'b0}}, bn_q};
					mp_sel = ad_q;
				end else if (op_q == OP_DIV) begin
					mp_sel = bn_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		op_d = op_q;
		status_d = status_q;
		an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q; mp_d = mp_q;
		sa_d = sa_q; sb_d = sb_q; sr_d = sr_q; cmp_d = cmp_q; dsel_d = dsel_q;
		rx_d = rx_q; ry_d = ry_q; gu_d = gu_q; gv_d = gv_q; g_d = g_q;
		dq_d = dq_q; dr_d = dr_q; mc_d = mc_q; acc_d = acc_q;
		p1_d = p1_q; p2_d = p2_q;
		gk_d = gk_q; cnt_d = cnt_q; mstep_d = mstep_q;
		m_tvalid_d = m_tvalid_q;
		onum_d = onum_q; oden_d = oden_q; ocmp_d = ocmp_q; ostat_d = ostat_q;
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b0;
		nb = 1'b0;
		q_n = '0;
		rem_n = '0;
		acc_n = acc_q;

		if (m_tvalid_q && m_tready)
			m_tvalid_d = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_d = op_t'(s_tuser);
					an_d = an_mag;
					ad_d = ad_mag;
					bn_d = bn_mag;
					bd_d = bd_mag;
					sa_d = an_in[W-1] ^ ad_in[W-1];
					sb_d = bn_in[W-1] ^ bd_in[W-1];
					status_d = (ad_in == '0 || bd_in == '0) ? STAT_DEN0 : STAT_OK;
					cmp_d = 1'b0;
					rx_d = {{W{1'b0}}, an_mag};
					ry_d = {{W{1'b0}}, ad_mag};
					phase_d = PH_A;
					state_d = ST_GCD_INIT;
				end
			end
			ST_GCD_INIT: begin
				gu_d = rx_q;
				gv_d = ry_q;
				gk_d = '0;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				// Binary GCD; gv stays nonzero throughout.
				if (gu_q == '0) begin
					g_d = gshift;
					dq_d = rx_q;
					dr_d = '0;
					cnt_d = '0;
					dsel_d = 1'b0;
					state_d = (gshift == M'(1)) ? ST_RED_DONE : ST_DIV;
				end else if (!gu_q[0] && !gv_q[0]) begin
					gu_d = gu_q >> 1;
					gv_d = gv_q >> 1;
					gk_d = gk_q + CW'(1);
				end else if (!gu_q[0]) begin
					gu_d = gu_q >> 1;
				end else if (!gv_q[0]) begin
					gv_d = gv_q >> 1;
				end else begin
					alu_a = {2'b00, gu_q};
					alu_b = {2'b00, gv_q};
					alu_sub = 1'b1;
					if (!alu_res[AW-1]) begin
						gu_d = alu_res[M:1];
					end else begin
						gu_d = gv_q;
						gv_d = gu_q;
					end
				end
			end
			ST_DIV: begin
				// Restoring division by the GCD, numerator first.
				alu_a = {1'b0, dr_q, dq_q[M-1]};
				alu_b = {2'b00, g_q};
				alu_sub = 1'b1;
				nb = !alu_res[AW-1];
				rem_n = nb ? alu_res[M-1:0] : {dr_q[M-2:0], dq_q[M-1]};
				q_n = {dq_q[M-2:0], nb};
				dr_d = rem_n;
				dq_d = q_n;
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(M - 1)) begin
					cnt_d = '0;
					if (!dsel_q) begin
						rx_d = q_n;
						dq_d = ry_q;
						dr_d = '0;
						dsel_d = 1'b1;
					end else begin
						ry_d = q_n;
						state_d = ST_RED_DONE;
					end
				end
			end
			ST_RED_DONE: begin
				case (phase_q)
					PH_A: begin
						an_d = rx_q[W-1:0];
						ad_d = ry_q[W-1:0];
						sa_d = sa_q && (rx_q != '0);
						rx_d = {{W{1'b0}}, bn_q};
						ry_d = {{W{1'b0}}, bd_q};
						phase_d = PH_B;
						state_d = ST_GCD_INIT;
					end
					PH_B: begin
						bn_d = rx_q[W-1:0];
						bd_d = ry_q[W-1:0];
						sb_d = sb_q && (rx_q != '0);
						state_d = ST_OP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_OP: begin
				mstep_d = 2'd0;
				sr_d = sa_q ^ sb_q;
				case (op_q)
					OP_ADD, OP_SUB, OP_MUL: state_d = ST_MUL_INIT;
					OP_DIV: begin
						if (bn_q == '0) begin
							status_d = STAT_DIV0;
							rx_d = '0;
							ry_d = M'(1);
							state_d = ST_DONE;
						end else begin
							state_d = ST_MUL_INIT;
						end
					end
					OP_EQ, OP_NE: begin
						cmp_d = ((sa_q == sb_q) && (an_q == bn_q) && (ad_q == bd_q))
							^ (op_q == OP_NE);
						rx_d = '0;
						ry_d = M'(1);
						state_d = ST_DONE;
					end
					default: begin
						status_d = STAT_OK;
						rx_d = '0;
						ry_d = M'(1);
						state_d = ST_DONE;
					end
				endcase
			end
			ST_MUL_INIT: begin
				mc_d = mc_sel;
				mp_d = mp_sel;
				acc_d = '0;
				cnt_d = '0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				alu_a = {2'b00, acc_q};
				alu_b = {2'b00, mc_q};
				acc_n = mp_q[0] ? alu_res[M-1:0] : acc_q;
				acc_d = acc_n;
				mc_d = mc_q << 1;
				mp_d = mp_q >> 1;
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					mstep_d = mstep_q + 2'd1;
					state_d = ST_MUL_INIT;
					if (addsub) begin
						case (mstep_q)
							2'd0: p1_d = acc_n;
							2'd1: p2_d = acc_n;
							default: begin
								ry_d = acc_n;
								state_d = ST_COMBINE;
							end
						endcase
					end else if (mstep_q == 2'd0) begin
						rx_d = acc_n;
					end else begin
						ry_d = acc_n;
						phase_d = PH_R;
						state_d = ST_GCD_INIT;
					end
				end
			end
			ST_COMBINE: begin
				// Sign-magnitude sum of the two cross products.
				alu_a = {2'b00, p1_q};
				alu_b = {2'b00, p2_q};
				alu_sub = (sa_q != s2);
				phase_d = PH_R;
				rx_d = alu_res[M-1:0];
				sr_d = sa_q;
				state_d = ST_GCD_INIT;
				if (alu_sub && alu_res[AW-1]) begin
					sr_d = s2;
					state_d = ST_NEG;
				end
			end
			ST_NEG: begin
				alu_a = {2'b00, p2_q};
				alu_b = {2'b00, p1_q};
				alu_sub = 1'b1;
				rx_d = alu_res[M-1:0];
				state_d = ST_GCD_INIT;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					onum_d = (sr_q && rx_q != '0) ? (~{1'b0, rx_q} + (M + 1)'(1))
						: {1'b0, rx_q};
					oden_d = ry_q[M-2:0];
					ocmp_d = cmp_q;
					ostat_d = status_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		phase_q <= phase_d;
		op_q <= op_d;
		status_q <= status_d;
		an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d; mp_q <= mp_d;
		sa_q <= sa_d; sb_q <= sb_d; sr_q <= sr_d; cmp_q <= cmp_d; dsel_q <= dsel_d;
		rx_q <= rx_d; ry_q <= ry_d; gu_q <= gu_d; gv_q <= gv_d; g_q <= g_d;
		dq_q <= dq_d; dr_q <= dr_d; mc_q <= mc_d; acc_q <= acc_d;
		p1_q <= p1_d; p2_q <= p2_d;
		gk_q <= gk_d; cnt_q <= cnt_d; mstep_q <= mstep_d;
		onum_q <= onum_d; oden_q <= oden_d; ocmp_q <= ocmp_d; ostat_q <= ostat_d;
	end

endmodule

/* sv/rau_checker.sv */
// Port-level checker of the rational arithmetic unit and its bind statement.
// Depends on rau_pkg and rational_arithmetic_unit_assert.svh.
`timescale 1ns / 1ps

`include "rational_arithmetic_unit_assert.svh"

module rau_checker
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16,
	localparam int OUT_TDW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [OUT_TDW-1:0] m_tdata,  // res_num, res_den
	input logic [2:0]         m_tuser   // cmp_true, status
);

	localparam int M = 2 * OPERAND_WIDTH;

	logic [M:0] num;
	logic [M-2:0] den;
	logic cmp_true;
	logic [STAT_W-1:0] status;

	assign num = m_tdata[M:0];
	assign den = m_tdata[2*M-1:M+1];
	assign cmp_true = m_tuser[0];
	assign status = m_tuser[2:1];

	`RAU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`RAU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`RAU_ASSERT_NOW(a_den_nonzero, m_tvalid, den != '0)
	`RAU_ASSERT_NOW(a_cmp_unit, m_tvalid && cmp_true, num == '0 && den == (M - 1)'(1))
	`RAU_ASSERT_NOW(a_div0_unit, m_tvalid && status == STAT_DIV0, num == '0 && den == (M - 1)'(1) && !cmp_true)

endmodule

bind rational_arithmetic_unit rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rau_checker (.*);
